// File: hw/rtl/aclp_pkg.sv
// aclp_pkg: shared types and constants for the ascii number literal parser
// holds status codes, character codes and the result record
// no dependencies; imported by every module of the block
package aclp_pkg;

    // accumulator width; the result keeps the low RESULT_BITS bits
    localparam int VALUE_BITS  = 32;
    localparam int RESULT_BITS = 32;
    localparam int LEN_BITS    = 8;
    localparam int CH_BITS     = 8;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INCOMPLETE = 3'd1,
        ST_INVALID    = 3'd2,
        ST_SYMBOL     = 3'd3,
        ST_FLOAT      = 3'd4,
        ST_MASK       = 3'd5
    } t_status;

    // character codes
    localparam logic [CH_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_BITS-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CH_BITS-1:0] CH_QUOTE  = 8'h27;
    localparam logic [CH_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_BITS-1:0] CH_A      = 8'h41;
    localparam logic [CH_BITS-1:0] CH_D      = 8'h44;
    localparam logic [CH_BITS-1:0] CH_F      = 8'h46;
    localparam logic [CH_BITS-1:0] CH_M      = 8'h4D;
    localparam logic [CH_BITS-1:0] CH_X      = 8'h58;
    localparam logic [CH_BITS-1:0] CH_Z      = 8'h5A;
    localparam logic [CH_BITS-1:0] CH_CARET  = 8'h5E;
    localparam logic [CH_BITS-1:0] CH_UNDER  = 8'h5F;

    // one finished text
    typedef struct packed {
        logic [LEN_BITS-1:0]    length;
        t_status                status;
        logic [RESULT_BITS-1:0] value;
    } t_result;

endpackage

// File: hw/rtl/aclp_parse.sv
// aclp_parse: per-character parser state and its one-step update
// consumes one registered character per enabled cycle, emits the text result
// depends on aclp_pkg
module aclp_parse
    import aclp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [CH_BITS-1:0]  i_ch,
    input  logic                i_last,
    input  logic                i_hex_default,
    output t_result             o_res
);

    typedef enum logic [2:0] {
        PH_FRESH,
        PH_HSTART,
        PH_DSTART,
        PH_DAFTERD,
        PH_HDIG,
        PH_DDIG
    } t_phase;

    typedef enum logic [1:0] {
        SG_NONE,
        SG_PLUS,
        SG_MINUS
    } t_sign;

    // saturating length counter add
    function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                    input logic [1:0] b);
        logic [LEN_BITS:0] s;
        s = {1'b0, a} + {{(LEN_BITS-1){1'b0}}, b};
        sat_add = s[LEN_BITS] ? {LEN_BITS{1'b1}} : s[LEN_BITS-1:0];
    endfunction

    // multiply by ten as two shifts and an add
    function automatic logic [VALUE_BITS-1:0] mul10(input logic [VALUE_BITS-1:0] a);
        mul10 = {a[VALUE_BITS-4:0], 3'b000} + {a[VALUE_BITS-2:0], 1'b0};
    endfunction

    t_phase                 r_phase, n_phase;
    logic [VALUE_BITS-1:0]  r_acc, n_acc;
    logic [VALUE_BITS-1:0]  r_nacc, n_nacc;   // running negated copy of the accumulator
    t_sign                  r_neg, n_neg;
    logic                   r_dseen, n_dseen;
    logic [LEN_BITS-1:0]    r_cons, n_cons;
    logic                   r_held, n_held;
    logic                   r_held_caret, n_held_caret;
    logic                   r_fin, n_fin;
    t_status                r_fin_status, n_fin_status;
    logic [VALUE_BITS-1:0]  r_fin_value, n_fin_value;

    // character classes
    logic                   c_blank, c_dec, c_hexl, c_sym;
    logic [3:0]             c_hex_val;

    assign c_blank   = (i_ch == CH_SPACE) || (i_ch == CH_TAB);
    assign c_dec     = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign c_hexl    = (i_ch >= CH_A) && (i_ch <= CH_F);
    assign c_sym     = ((i_ch >= CH_A) && (i_ch <= CH_Z)) || (i_ch == CH_UNDER)
                       || (i_ch == CH_DOLLAR) || (i_ch == CH_QUOTE);
    assign c_hex_val = c_dec ? i_ch[3:0] : 4'(i_ch[3:0] + 4'd9);

    // one parser step plus end-of-text resolution
    always_comb begin
        t_phase                ph0;
        t_phase                e_ph;
        t_sign                 e_neg;
        logic                  e_dseen;
        logic [1:0]            e_pre;
        logic                  do_dig;
        logic [1:0]            inc;
        logic [VALUE_BITS-1:0] dec_val;
        logic [VALUE_BITS-1:0] res_val;

        ph0          = (r_phase == PH_FRESH) ? (i_hex_default ? PH_HSTART : PH_DSTART)
                                             : r_phase;
        n_phase      = ph0;
        n_acc        = r_acc;
        n_nacc       = r_nacc;
        n_neg        = r_neg;
        n_dseen      = r_dseen;
        n_held       = r_held;
        n_held_caret = r_held_caret;
        n_fin        = r_fin;
        n_fin_status = r_fin_status;
        n_fin_value  = r_fin_value;
        e_ph         = ph0;
        e_neg        = r_neg;
        e_dseen      = r_dseen;
        e_pre        = 2'd0;
        do_dig       = 1'b0;
        inc          = 2'd0;
        dec_val      = '0;
        res_val      = '0;

        if (!r_fin) begin
            if (r_held) begin
                // resolve a pending caret or zero
                n_held = 1'b0;
                if (r_held_caret) begin
                    if (i_ch == CH_F) begin
                        inc          = 2'd2;
                        n_fin        = 1'b1;
                        n_fin_status = ST_FLOAT;
                        n_fin_value  = '0;
                    end else if (ph0 == PH_HSTART && i_ch == CH_D) begin
                        inc     = 2'd2;
                        n_phase = PH_DSTART;
                    end else if (ph0 == PH_HSTART && i_ch == CH_M) begin
                        inc          = 2'd2;
                        n_fin        = 1'b1;
                        n_fin_status = ST_MASK;
                        n_fin_value  = '0;
                    end else if (ph0 != PH_DAFTERD && i_ch == CH_X) begin
                        inc     = 2'd2;
                        n_phase = PH_HDIG;
                    end else if (ph0 == PH_DSTART && i_ch == CH_D) begin
                        inc     = 2'd2;
                        n_phase = PH_DAFTERD;
                    end else begin
                        n_fin        = 1'b1;
                        n_fin_status = ST_INVALID;
                        n_fin_value  = '0;
                    end
                end else if (i_ch == CH_X) begin
                    inc     = 2'd2;
                    n_phase = PH_HDIG;
                end else begin
                    // the held zero counts as a first digit
                    do_dig  = 1'b1;
                    e_ph    = (ph0 == PH_HSTART) ? PH_HDIG : PH_DDIG;
                    e_dseen = 1'b1;
                    e_neg   = (ph0 == PH_HSTART) ? r_neg : SG_PLUS;
                    e_pre   = 2'd1;
                end
            end else if (ph0 == PH_HDIG || ph0 == PH_DDIG) begin
                do_dig = 1'b1;
            end else begin
                // start of literal
                if (ph0 != PH_DAFTERD && c_blank) begin
                    inc = 2'd1;
                end else if (i_ch == CH_CARET) begin
                    n_held       = 1'b1;
                    n_held_caret = 1'b1;
                end else if (i_ch == CH_ZERO && ph0 != PH_DAFTERD) begin
                    n_held       = 1'b1;
                    n_held_caret = 1'b0;
                end else if (c_sym) begin
                    n_fin        = 1'b1;
                    n_fin_status = ST_SYMBOL;
                    n_fin_value  = '0;
                end else begin
                    do_dig = 1'b1;
                    e_ph   = (ph0 == PH_HSTART) ? PH_HDIG : PH_DDIG;
                end
            end
        end

        // digit handling on the effective state
        if (do_dig) begin
            n_phase = e_ph;
            n_neg   = e_neg;
            n_dseen = e_dseen;
            inc     = e_pre;
            dec_val = (e_neg == SG_MINUS) ? r_nacc : r_acc;
            if (e_ph == PH_HDIG) begin
                if (c_dec || c_hexl) begin
                    n_acc   = {r_acc[VALUE_BITS-5:0], c_hex_val};
                    n_dseen = 1'b1;
                    inc     = 2'(e_pre + 2'd1);
                end else begin
                    n_fin        = 1'b1;
                    n_fin_status = e_dseen ? ST_OK : ST_INVALID;
                    n_fin_value  = r_acc;
                end
            end else if (i_ch == CH_PLUS || i_ch == CH_MINUS) begin
                if (e_neg != SG_NONE) begin
                    n_fin        = 1'b1;
                    n_fin_status = e_dseen ? ST_OK : ST_INVALID;
                    n_fin_value  = dec_val;
                end else begin
                    n_neg = (i_ch == CH_MINUS) ? SG_MINUS : SG_PLUS;
                    inc   = 2'(e_pre + 2'd1);
                end
            end else if (c_dec) begin
                if (e_neg == SG_NONE)
                    n_neg = SG_PLUS;
                n_acc   = mul10(r_acc) + VALUE_BITS'(i_ch[3:0]);
                n_nacc  = mul10(r_nacc) - VALUE_BITS'(i_ch[3:0]);
                n_dseen = 1'b1;
                inc     = 2'(e_pre + 2'd1);
            end else begin
                n_fin        = 1'b1;
                n_fin_status = e_dseen ? ST_OK : ST_INVALID;
                n_fin_value  = dec_val;
            end
        end

        n_cons = sat_add(r_cons, inc);

        // end of text resolution for the result
        o_res.length = n_cons;
        if (n_fin) begin
            o_res.status = n_fin_status;
            res_val      = n_fin_value;
        end else if (n_held) begin
            if (n_held_caret) begin
                o_res.status = ST_INVALID;
            end else begin
                o_res.status = ST_OK;
                o_res.length = sat_add(n_cons, 2'd1);
            end
        end else begin
            case (n_phase)
                PH_HSTART: o_res.status = ST_INCOMPLETE;
                PH_HDIG: begin
                    o_res.status = n_dseen ? ST_OK : ST_INVALID;
                    res_val      = n_acc;
                end
                PH_DDIG: begin
                    o_res.status = n_dseen ? ST_OK : ST_INVALID;
                    res_val      = (n_neg == SG_MINUS) ? n_nacc : n_acc;
                end
                default: o_res.status = ST_INVALID;
            endcase
        end
        o_res.value = RESULT_BITS'(res_val);
    end

    // parser state, cleared at the end of every text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_last)) begin
            r_phase      <= PH_FRESH;
            r_acc        <= '0;
            r_nacc       <= '0;
            r_neg        <= SG_NONE;
            r_dseen      <= 1'b0;
            r_cons       <= '0;
            r_held       <= 1'b0;
            r_held_caret <= 1'b0;
            r_fin        <= 1'b0;
            r_fin_status <= ST_OK;
            r_fin_value  <= '0;
        end else if (i_go) begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_nacc       <= n_nacc;
            r_neg        <= n_neg;
            r_dseen      <= n_dseen;
            r_cons       <= n_cons;
            r_held       <= n_held;
            r_held_caret <= n_held_caret;
            r_fin        <= n_fin;
            r_fin_status <= n_fin_status;
            r_fin_value  <= n_fin_value;
        end
    end

endmodule

// File: hw/rtl/aclp_out_reg.sv
// aclp_out_reg: result register on the master side of the stream
// holds one finished result until the downstream side takes it
// depends on aclp_pkg
module aclp_out_reg
    import aclp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // valid flag: set on load, cleared when the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_valid <= 1'b0;
        else if (i_load)
            r_valid <= 1'b1;
        else if (i_ready)
            r_valid <= 1'b0;
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load)
            r_res <= i_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hw/rtl/ascii_number_literal_parser.sv
// ascii_number_literal_parser: top level of the ascii number literal parser
// input register, parser step, result register and the radix register
// depends on aclp_pkg, aclp_parse, aclp_out_reg
//
//  channel   | direction | signals                          | carries
//  ----------+-----------+----------------------------------+---------------------------
//  s_axis    | in        | tvalid tready tdata[7:0] tlast   | one character, end of text
//  m_axis    | out       | tvalid tready tdata[47:0]        | value, status, length
//  cfg       | in        | valid ready data[0]              | default radix, 1 = hex
//
// a character is taken every cycle unless a last one waits; one step is one parser pass
// a result is registered when its last character leaves the input register
// reset (synchronous, active low) returns to hex radix and an empty text
// a stalled result holds back only a last character; other characters keep flowing
module ascii_number_literal_parser
    import aclp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_s_axis_tlast,
    // results
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [31:0] value, [34:32] status, [42:35] length
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    logic               r_in_valid;
    logic [CH_BITS-1:0] r_in_ch;
    logic               r_in_last;
    logic               r_hex_default;
    logic               out_free;
    logic               step_go;
    t_result            step_res;
    t_result            out_res;

    // radix register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_hex_default <= 1'b1;
        else if (i_cfg_valid)
            r_hex_default <= i_cfg_data;
    end

    // flow control between input register, parser and result register
    assign out_free        = !o_m_axis_tvalid || i_m_axis_tready;
    assign step_go         = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || step_go;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else if (i_s_axis_tvalid && o_s_axis_tready)
            r_in_valid <= 1'b1;
        else if (step_go)
            r_in_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_ch   <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // parser step
    aclp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (step_go),
        .i_ch          (r_in_ch),
        .i_last        (r_in_last),
        .i_hex_default (r_hex_default),
        .o_res         (step_res)
    );

    // result register
    aclp_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step_go && r_in_last),
        .i_res   (step_res),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {5'd0, out_res.length, out_res.status, out_res.value};

    // a new result only follows a last character leaving the input register
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(step_go && r_in_last))
        else $error("result without a last character");

    // input side only stalls while a character is held
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid)
        else $error("input stalled with empty input register");

    // a last character never overwrites a pending result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_go && r_in_last) |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result register overwritten");

    // status code stays within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (out_res.status == ST_OK || out_res.status == ST_INCOMPLETE
                             || out_res.status == ST_INVALID || out_res.status == ST_SYMBOL
                             || out_res.status == ST_FLOAT || out_res.status == ST_MASK))
        else $error("undefined status code");

endmodule

// File: tb/tb_ascii_number_literal_parser.sv
`timescale 1ns / 100ps
// tb_ascii_number_literal_parser: self-checking testbench for the ascii number literal parser
// drives texts one character per request, predicts each result and compares it field by field
// depends on aclp_pkg and ascii_number_literal_parser
module tb_ascii_number_literal_parser
    import aclp_pkg::*;
();

    localparam int RANDOM_CHARS = 1000;
    localparam int MAX_GAP      = 18;
    localparam int SETTLE       = 4;
    localparam int REPORT_MAX   = 10;

    // scan phase of the literal inside one text
    typedef enum logic [2:0] {
        SCAN_FRESH,
        SCAN_HEX_START,
        SCAN_DEC_START,
        SCAN_DEC_AFTER_D,
        SCAN_HEX_DIGITS,
        SCAN_DEC_DIGITS
    } t_scan;

    typedef enum logic [1:0] {
        SIGN_NONE,
        SIGN_PLUS,
        SIGN_MINUS
    } t_sign;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    // literal tracker state
    logic        radix_hex;
    t_scan       scan;
    logic [31:0] acc;
    t_sign       sign;
    logic        got_digit;
    int unsigned used;
    logic        held;
    logic        held_caret;
    logic        done;
    t_status     done_status;
    logic [31:0] done_value;

    t_result     expected_results[$];
    logic [7:0]  text_buf[$];
    int unsigned chars_sent = 0;
    int unsigned mismatches = 0;
    logic        send_fast = 1'b0;
    logic        sink_fast = 1'b0;
    int unsigned sink_wait = 0;

    ascii_number_literal_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] ch
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [31:0] value, [34:32] status, [42:35] length
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- literal tracker

    function automatic void text_clear();
        scan        = SCAN_FRESH;
        acc         = '0;
        sign        = SIGN_NONE;
        got_digit   = 1'b0;
        used        = 0;
        held        = 1'b0;
        held_caret  = 1'b0;
        done        = 1'b0;
        done_status = ST_OK;
        done_value  = '0;
    endfunction

    function automatic void count_char();
        if (used < 255) used++;
    endfunction

    function automatic void close_literal(input t_status st, input logic [31:0] v);
        done        = 1'b1;
        done_status = st;
        done_value  = v;
    endfunction

    function automatic logic [31:0] signed_value();
        return (sign == SIGN_MINUS) ? 32'd0 - acc : acc;
    endfunction

    function automatic logic is_symbol_char(input logic [7:0] c);
        return (c >= CH_A && c <= CH_Z) || c == CH_UNDER || c == CH_DOLLAR || c == CH_QUOTE;
    endfunction

    // one character inside the digit run
    function automatic void take_digit(input logic [7:0] c);
        logic [7:0] d;
        if (scan == SCAN_HEX_DIGITS) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
            end else if (c >= CH_A && c <= CH_F) begin
                d = c - CH_A + 8'd10;
            end else begin
                close_literal(got_digit ? ST_OK : ST_INVALID, acc);
                return;
            end
            acc = {acc[27:0], d[3:0]};
            got_digit = 1'b1;
            count_char();
            return;
        end
        if (c == CH_PLUS || c == CH_MINUS) begin
            // a second sign ends the literal
            if (sign != SIGN_NONE) begin
                close_literal(got_digit ? ST_OK : ST_INVALID, signed_value());
                return;
            end
            sign = (c == CH_MINUS) ? SIGN_MINUS : SIGN_PLUS;
            count_char();
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (sign == SIGN_NONE) sign = SIGN_PLUS;
            acc = acc * 32'd10 + {24'd0, c - CH_ZERO};
            got_digit = 1'b1;
            count_char();
            return;
        end
        close_literal(got_digit ? ST_OK : ST_INVALID, signed_value());
    endfunction

    // one character where a literal may still start
    function automatic void take_start(input logic [7:0] c);
        if (scan != SCAN_DEC_AFTER_D && (c == CH_SPACE || c == CH_TAB)) begin
            count_char();
            return;
        end
        if (c == CH_CARET) begin
            held       = 1'b1;
            held_caret = 1'b1;
            return;
        end
        if (c == CH_ZERO && scan != SCAN_DEC_AFTER_D) begin
            held       = 1'b1;
            held_caret = 1'b0;
            return;
        end
        if (is_symbol_char(c)) begin
            close_literal(ST_SYMBOL, '0);
            return;
        end
        scan = (scan == SCAN_HEX_START) ? SCAN_HEX_DIGITS : SCAN_DEC_DIGITS;
        take_digit(c);
    endfunction

    // character following a pending caret or zero
    function automatic void resolve_prefix(input logic [7:0] c);
        held = 1'b0;
        if (held_caret) begin
            if (c == CH_F) begin
                count_char(); count_char();
                close_literal(ST_FLOAT, '0);
            end else if (scan == SCAN_HEX_START && c == CH_D) begin
                count_char(); count_char();
                scan = SCAN_DEC_START;
            end else if (scan == SCAN_HEX_START && c == CH_M) begin
                count_char(); count_char();
                close_literal(ST_MASK, '0);
            end else if (scan != SCAN_DEC_AFTER_D && c == CH_X) begin
                count_char(); count_char();
                scan = SCAN_HEX_DIGITS;
            end else if (scan == SCAN_DEC_START && c == CH_D) begin
                count_char(); count_char();
                scan = SCAN_DEC_AFTER_D;
            end else begin
                close_literal(ST_INVALID, '0);
            end
            return;
        end
        if (c == CH_X) begin
            count_char(); count_char();
            scan = SCAN_HEX_DIGITS;
            return;
        end
        scan = (scan == SCAN_HEX_START) ? SCAN_HEX_DIGITS : SCAN_DEC_DIGITS;
        take_digit(CH_ZERO);
        if (!done) take_digit(c);
    endfunction

    // end of text with the literal still open
    function automatic void close_text();
        if (held) begin
            held = 1'b0;
            if (held_caret) begin
                close_literal(ST_INVALID, '0);
            end else begin
                count_char();
                close_literal(ST_OK, '0);
            end
            return;
        end
        case (scan)
            SCAN_HEX_START:  close_literal(ST_INCOMPLETE, '0);
            SCAN_HEX_DIGITS: close_literal(got_digit ? ST_OK : ST_INVALID, acc);
            SCAN_DEC_DIGITS: close_literal(got_digit ? ST_OK : ST_INVALID, signed_value());
            default:         close_literal(ST_INVALID, '0);
        endcase
    endfunction

    // advance the tracker by one accepted character; queue the result at end of text
    function automatic void predict_char(input logic [7:0] c, input logic lst);
        t_result r;
        if (scan == SCAN_FRESH) scan = radix_hex ? SCAN_HEX_START : SCAN_DEC_START;
        if (!done) begin
            if (held) resolve_prefix(c);
            else if (scan == SCAN_HEX_DIGITS || scan == SCAN_DEC_DIGITS) take_digit(c);
            else take_start(c);
        end
        if (lst) begin
            if (!done) close_text();
            r.value  = done_value;
            r.status = done_status;
            r.length = used[7:0];
            expected_results.push_back(r);
            text_clear();
        end
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("mismatch: %s", msg);
    endfunction

    // ---------------------------------------------------------------- monitor and result sink

    // check results, then track accepted characters and register writes
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("unexpected result value %h status %0d length %0d",
                        m_tdata[31:0], m_tdata[34:32], m_tdata[42:35]));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[31:0] != want.value || m_tdata[34:32] != want.status ||
                        m_tdata[42:35] != want.length)
                        flag_error($sformatf(
                            "expected value %h status %0d length %0d, got %h %0d %0d",
                            want.value, want.status, want.length,
                            m_tdata[31:0], m_tdata[34:32], m_tdata[42:35]));
                end
            end
            if (s_tvalid && s_tready) predict_char(s_tdata, s_tlast);
            if (cfg_valid && cfg_ready) radix_hex = cfg_data;
        end
    end

    // result ready with a random stall after each result, sometimes none
    always @(posedge i_clk) begin : result_sink
        int unsigned n;
        if (!rst_n) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                if ($urandom_range(0, 15) == 0) sink_fast = !sink_fast;
                n = sink_fast ? 0 : $urandom_range(0, MAX_GAP);
                if (n > 0) begin
                    m_tready  <= 1'b0;
                    sink_wait <= n;
                end
            end
        end else if (sink_wait > 1) begin
            sink_wait <= sink_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stimulus helpers

    // one character request, after a random gap
    task automatic send_char(input logic [7:0] c, input logic lst);
        int unsigned gap;
        gap = send_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        do @(posedge i_clk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_text();
        send_fast = ($urandom_range(0, 3) == 0);
        foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_text();
    endtask

    // stop sending until every result is back, then let the pipeline drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic hex);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= hex;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // half the time characters that steer the parser, otherwise any byte
    function automatic logic [7:0] random_char();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 16))
            0:  return CH_SPACE;
            1:  return CH_TAB;
            2:  return CH_CARET;
            3:  return CH_ZERO;
            4:  return CH_X;
            5:  return CH_D;
            6:  return CH_F;
            7:  return CH_M;
            8:  return CH_PLUS;
            9:  return CH_MINUS;
            10: return CH_UNDER;
            11: return CH_DOLLAR;
            12: return CH_QUOTE;
            13: return CH_A;
            14: return CH_Z;
            15: return CH_NINE;
            default: return 8'h47;
        endcase
    endfunction

    // blanks, prefix, signs, digits and trailing characters, each drawn at random
    task automatic build_literal();
        int unsigned n;
        logic        all_max;
        logic        hex_digits;
        logic [7:0]  d;
        n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n) text_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        case ($urandom_range(0, 11))
            0: begin text_buf.push_back(CH_CARET); text_buf.push_back(CH_X); end
            1: begin text_buf.push_back(CH_ZERO);  text_buf.push_back(CH_X); end
            2: begin text_buf.push_back(CH_CARET); text_buf.push_back(CH_D); end
            3: begin
                text_buf.push_back(CH_CARET); text_buf.push_back(CH_D);
                text_buf.push_back(CH_CARET); text_buf.push_back(CH_D);
            end
            4: begin text_buf.push_back(CH_CARET); text_buf.push_back(CH_F); end
            5: begin text_buf.push_back(CH_CARET); text_buf.push_back(CH_M); end
            6: begin text_buf.push_back(CH_CARET); text_buf.push_back(random_char()); end
            default: ;
        endcase
        case ($urandom_range(0, 5))
            0: text_buf.push_back(CH_MINUS);
            1: text_buf.push_back(CH_PLUS);
            2: begin
                text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            end
            default: ;
        endcase
        n          = $urandom_range(0, 12);
        all_max    = ($urandom_range(0, 15) == 0);
        hex_digits = 1'($urandom_range(0, 1));
        repeat (n) begin
            if (all_max) d = hex_digits ? CH_F : CH_NINE;
            else if (hex_digits) d = 8'($urandom_range(0, 15));
            else d = 8'($urandom_range(0, 9));
            if (!all_max) d = (d < 10) ? CH_ZERO + d : CH_A + d - 8'd10;
            text_buf.push_back(d);
        end
        repeat ($urandom_range(0, 2)) text_buf.push_back(random_char());
        if (text_buf.size() == 0) text_buf.push_back(random_char());
    endtask

    // ---------------------------------------------------------------- tests

    // reset radix is hex: blanks, the ^F, ^M, 0X and ^D prefixes, symbols and byte extremes
    task automatic test_hex_prefixes();
        send_string(" \t^");
        send_string("^F");
        send_string("^M");
        send_string("$");
        send_string(" ");
        send_string("0X7G");
        send_string("^D-9");
        send_string("0");
        text_buf.push_back(8'hFF);
        send_text();
        text_buf.push_back(8'h00);
        send_text();
    endtask

    // decimal radix: blank-only text, skipped ^D, double sign, ^M not a prefix
    task automatic test_decimal_forms();
        write_radix(1'b0);
        send_string("\t");
        send_string("^D+4");
        send_string("--1");
        send_string("^M");
    endtask

    // consumed length saturates on a long run of blanks
    task automatic test_length_saturation();
        write_radix(1'b1);
        repeat (300) text_buf.push_back(CH_SPACE);
        text_buf.push_back(8'h31);
        text_buf.push_back(CH_A);
        send_text();
    endtask

    // random texts, mostly well-formed literals, with radix changes between phases
    task automatic test_random_texts();
        int unsigned texts;
        int unsigned stop_at;
        texts   = 0;
        stop_at = chars_sent + RANDOM_CHARS;
        while (chars_sent < stop_at) begin
            if (texts % 24 == 23) write_radix(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 8)) text_buf.push_back(random_char());
            end else begin
                build_literal();
            end
            send_text();
            texts++;
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        radix_hex = 1'b1;
        text_clear();
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_hex_prefixes();
        test_decimal_forms();
        test_length_saturation();
        test_random_texts();
        wait_idle();
        repeat (2 * SETTLE) @(posedge i_clk);
        if (expected_results.size() != 0) flag_error("results still expected at end of run");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #500_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: ascii_number_literal_parser.f
hw/rtl/aclp_pkg.sv
hw/rtl/aclp_parse.sv
hw/rtl/aclp_out_reg.sv
hw/rtl/ascii_number_literal_parser.sv
tb/tb_ascii_number_literal_parser.sv
